// ===== rtl/bwet_pkg.sv =====
// ----------------------------------------------------------------------------
// bwet_pkg
// shared constants, command and status codes, store interface types and
// bit search helpers for the bitmap with extreme tracking
// ----------------------------------------------------------------------------
package bwet_pkg;

	localparam int MAX_BITS = 1024;
	localparam int POS_W    = 10;
	localparam int CNT_W    = 11;
	localparam int BYTE_W   = 8;
	localparam int SEL_W    = 3;
	localparam int ROWS     = MAX_BITS / BYTE_W;
	localparam int ROW_W    = $clog2(ROWS);
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 32;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_WIPE  = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_WAS_SET = 2'd1;
	localparam logic [1:0] STAT_WAS_CLR = 2'd2;
	localparam logic [1:0] STAT_RANGE   = 2'd3;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] row;
	} store_rd_t;

	typedef struct packed {
		logic              en;
		logic              clr;
		logic [ROW_W-1:0]  row;
		logic [BYTE_W-1:0] data;
	} store_wr_t;

	function automatic logic [SEL_W-1:0] lowest_bit(input logic [BYTE_W-1:0] b);
		logic [SEL_W-1:0] r;
		r = '0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (b[i]) begin
				r = SEL_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [SEL_W-1:0] highest_bit(input logic [BYTE_W-1:0] b);
		logic [SEL_W-1:0] r;
		r = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (b[i]) begin
				r = SEL_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/bitmap_with_extreme_tracking.sv =====
// ----------------------------------------------------------------------------
// bitmap_with_extreme_tracking
// bitmap of marks with set count and lowest / highest set position tracking
//
//   channel  direction  fields (low bit first)
//   s_*      in         tuser: command[1:0]; tdata: bit_position[9:0]
//   m_*      out        tdata: bit_value, ones_count, lowest_set, highest_set
//                       tuser: status[1:0]
//   cfg_*    in         wr_data: active_bits[10:0]
//
// read, set, clear and map wipe do one memory read, then a write-back where the map changes
// clearing the lowest or highest mark may add an inward scan of mark rows, one row
// per memory read, up to 127 rows, bounded by the single memory read port
// reset and map wipe clear the row valid bits at once, no clearing pass
// one request at a time; a finished result waits in the output register while
// the next request is taken, whose write-back holds until that result leaves
// ----------------------------------------------------------------------------
module bitmap_with_extreme_tracking
	import bwet_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CNT_W-1:0]    cfg_wr_data,    // active_bits
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,        // bit_position
	input  logic [1:0]          s_tuser,        // command
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,        // bit_value, ones_count, lowest_set, highest_set
	output logic [1:0]          m_tuser         // status
);

	logic [CNT_W-1:0]  active_bits_q;
	logic [CNT_W-1:0]  limit;
	store_rd_t         rd;
	store_wr_t         wr;
	logic [BYTE_W-1:0] rd_byte;
	logic              bit_value;
	logic [CNT_W-1:0]  ones_count;
	logic [POS_W-1:0]  lowest_set, highest_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bits_q <= CNT_W'(MAX_BITS);
		end else if (cfg_wr_en) begin
			active_bits_q <= cfg_wr_data;
		end
	end

	assign limit = (active_bits_q > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : active_bits_q;

	bwet_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.wr      (wr),
		.rd_byte (rd_byte)
	);

	bwet_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit       (limit),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_cmd       (s_tuser),
		.s_pos       (s_tdata[POS_W-1:0]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.bit_value   (bit_value),
		.ones_count  (ones_count),
		.lowest_set  (lowest_set),
		.highest_set (highest_set),
		.status      (m_tuser),
		.rd          (rd),
		.wr          (wr),
		.rd_byte     (rd_byte)
	);

	assign m_tdata = M_DATA_W'({highest_set, lowest_set, ones_count, bit_value});

endmodule

// ===== rtl/bwet_store.sv =====
// ----------------------------------------------------------------------------
// bwet_store
// byte-wide mark memory with one registered read port, one write port and
// a valid bit per row so that reset and map wipe clear it at once
// ----------------------------------------------------------------------------
module bwet_store
	import bwet_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  store_rd_t         rd,
	input  store_wr_t         wr,
	output logic [BYTE_W-1:0] rd_byte
);

	logic [BYTE_W-1:0] mem [ROWS];
	logic [ROWS-1:0]   row_vld_q;
	logic [BYTE_W-1:0] rd_data_s1;
	logic              rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.row] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_s1 <= mem[rd.row];
			rd_vld_s1  <= row_vld_q[rd.row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr.clr) begin
			row_vld_q <= '0;
		end else if (wr.en) begin
			row_vld_q[wr.row] <= 1'b1;
		end
	end

	// rows never written since the last wipe read as zero
	assign rd_byte = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

// ===== rtl/bwet_ctrl.sv =====
// ----------------------------------------------------------------------------
// bwet_ctrl
// command sequencer: read-modify-write of one mark row, count and extreme
// upkeep, inward row scan for a new extreme, and the result register
// ----------------------------------------------------------------------------
module bwet_ctrl
	import bwet_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CNT_W-1:0]  limit,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        s_cmd,
	input  logic [POS_W-1:0]  s_pos,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              bit_value,
	output logic [CNT_W-1:0]  ones_count,
	output logic [POS_W-1:0]  lowest_set,
	output logic [POS_W-1:0]  highest_set,
	output logic [1:0]        status,
	output store_rd_t         rd,
	output store_wr_t         wr,
	input  logic [BYTE_W-1:0] rd_byte
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RMW  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [1:0]       cmd_s1;
	logic [POS_W-1:0] pos_s1;
	logic [CNT_W-1:0] count_q, count_d;
	logic [POS_W-1:0] low_q, low_d, high_q, high_d;
	logic [ROW_W-1:0] scan_row_q, scan_row_d;
	logic             scan_up_q, scan_up_d;

	logic              m_valid_q;
	logic              res_bit_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [POS_W-1:0]  res_low_q, res_high_q;
	logic [1:0]        res_stat_q;

	logic              emit, res_bit;
	logic [1:0]        res_stat;
	logic              out_free, oor, cur;
	logic [ROW_W-1:0]  row_s1;
	logic [SEL_W-1:0]  sel;
	logic [BYTE_W-1:0] bit_mask, below, set_byte, clr_byte, up_bits, down_bits;
	logic [POS_W-1:0]  other, found;

	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign row_s1    = ROW_W'(pos_s1 >> SEL_W);
	assign sel       = pos_s1[SEL_W-1:0];
	assign bit_mask  = BYTE_W'(1) << sel;
	assign below     = bit_mask - BYTE_W'(1);
	assign cur       = |(rd_byte & bit_mask);
	assign set_byte  = rd_byte | bit_mask;
	assign clr_byte  = rd_byte & ~bit_mask;
	assign up_bits   = clr_byte & ~below;
	assign down_bits = clr_byte & below;
	assign oor       = CNT_W'(pos_s1) >= limit;
	assign other     = (pos_s1 == low_q) ? high_q : low_q;
	assign found     = POS_W'({scan_row_q,
		scan_up_q ? lowest_bit(rd_byte) : highest_bit(rd_byte)});

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		low_d      = low_q;
		high_d     = high_q;
		scan_row_d = scan_row_q;
		scan_up_d  = scan_up_q;
		emit       = 1'b0;
		res_bit    = 1'b0;
		res_stat   = STAT_OK;
		rd         = '0;
		wr         = '0;
		wr.row     = row_s1;

		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					rd.en   = 1'b1;
					rd.row  = ROW_W'(s_pos >> SEL_W);
					state_d = S_RMW;
				end
			end
			S_RMW: begin
				if (out_free) begin
					emit = 1'b1;
					if (cmd_s1 == CMD_WIPE) begin
						wr.clr  = 1'b1;
						count_d = '0;
						low_d   = '0;
						high_d  = '0;
					end else if (oor) begin
						res_stat = STAT_RANGE;
					end else begin
						case (cmd_s1)
							CMD_READ: begin
								res_bit = cur;
							end
							CMD_SET: begin
								res_bit = 1'b1;
								if (cur) begin
									res_stat = STAT_WAS_SET;
								end else begin
									wr.en   = 1'b1;
									wr.data = set_byte;
									count_d = count_q + CNT_W'(1);
									if (count_q == '0) begin
										low_d  = pos_s1;
										high_d = pos_s1;
									end else begin
										low_d  = (pos_s1 < low_q) ? pos_s1 : low_q;
										high_d = (pos_s1 > high_q) ? pos_s1 : high_q;
									end
								end
							end
							default: begin
								if (!cur) begin
									res_stat = STAT_WAS_CLR;
								end else begin
									wr.en   = 1'b1;
									wr.data = clr_byte;
									count_d = count_q - CNT_W'(1);
									if (count_q == CNT_W'(1)) begin
										low_d  = '0;
										high_d = '0;
									end else if (count_q == CNT_W'(2)) begin
										low_d  = other;
										high_d = other;
									end else if (pos_s1 == low_q) begin
										if (up_bits != '0) begin
											low_d = POS_W'({row_s1, lowest_bit(up_bits)});
										end else begin
											emit       = 1'b0;
											rd.en      = 1'b1;
											rd.row     = row_s1 + ROW_W'(1);
											scan_row_d = row_s1 + ROW_W'(1);
											scan_up_d  = 1'b1;
										end
									end else if (pos_s1 == high_q) begin
										if (down_bits != '0) begin
											high_d = POS_W'({row_s1, highest_bit(down_bits)});
										end else begin
											emit       = 1'b0;
											rd.en      = 1'b1;
											rd.row     = row_s1 - ROW_W'(1);
											scan_row_d = row_s1 - ROW_W'(1);
											scan_up_d  = 1'b0;
										end
									end
								end
							end
						endcase
					end
					state_d = emit ? S_IDLE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (rd_byte != '0) begin
					if (out_free) begin
						emit = 1'b1;
						if (scan_up_q) begin
							low_d = found;
						end else begin
							high_d = found;
						end
						state_d = S_IDLE;
					end
				end else begin
					rd.en      = 1'b1;
					rd.row     = scan_up_q ? scan_row_q + ROW_W'(1) : scan_row_q - ROW_W'(1);
					scan_row_d = rd.row;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			low_q     <= '0;
			high_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			low_q   <= low_d;
			high_q  <= high_d;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_row_q <= scan_row_d;
		scan_up_q  <= scan_up_d;
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_cmd;
			pos_s1 <= s_pos;
		end
		if (emit) begin
			res_bit_q  <= res_bit;
			res_cnt_q  <= count_d;
			res_low_q  <= low_d;
			res_high_q <= high_d;
			res_stat_q <= res_stat;
		end
	end

	assign m_tvalid    = m_valid_q;
	assign bit_value   = res_bit_q;
	assign ones_count  = res_cnt_q;
	assign lowest_set  = res_low_q;
	assign highest_set = res_high_q;
	assign status      = res_stat_q;

	a_empty_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (low_q == '0 && high_q == '0))
		else $error("marks not zero with empty map");

	a_mark_order: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= high_q)
		else $error("lowest mark above highest mark");

	a_scan_up_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && scan_up_q) |-> (scan_row_q <= ROW_W'(high_q >> SEL_W)))
		else $error("upward scan passed the highest mark");

	a_scan_down_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !scan_up_q) |-> (scan_row_q >= ROW_W'(low_q >> SEL_W)))
		else $error("downward scan passed the lowest mark");

endmodule
